// ----- hdl/tle_pkg.sv -----
package tle_pkg;

	// Default line store depth.
	localparam int LINE_DEPTH_DEF = 64;

	// Byte codes used by the editor.
	localparam logic [7:0] KEY_BS     = 8'h08;
	localparam logic [7:0] KEY_TAB    = 8'h09;
	localparam logic [7:0] KEY_LF     = 8'h0a;
	localparam logic [7:0] KEY_CR     = 8'h0d;
	localparam logic [7:0] KEY_CTLR   = 8'h12;
	localparam logic [7:0] KEY_CTLU   = 8'h15;
	localparam logic [7:0] KEY_CTLV   = 8'h16;
	localparam logic [7:0] KEY_CTLW   = 8'h17;
	localparam logic [7:0] KEY_SP     = 8'h20;
	localparam logic [7:0] KEY_RUBOUT = 8'h7f;
	localparam logic [7:0] BYTE_NUL   = 8'h00;
	localparam logic [7:0] IAC_BYTE   = 8'hff;

	// Telnet commands.
	localparam logic [7:0] TN_BRK  = 8'd243;
	localparam logic [7:0] TN_IP   = 8'd244;
	localparam logic [7:0] TN_AO   = 8'd245;
	localparam logic [7:0] TN_AYT  = 8'd246;
	localparam logic [7:0] TN_EC   = 8'd247;
	localparam logic [7:0] TN_EL   = 8'd248;
	localparam logic [7:0] TN_NONE = 8'd0;

	// Low five bits of the key that follows the escape byte.
	localparam logic [4:0] ESC_K_BRK  = 5'h02;
	localparam logic [4:0] ESC_K_IP   = 5'h03;
	localparam logic [4:0] ESC_K_AO   = 5'h0f;
	localparam logic [4:0] ESC_K_AYT  = 5'h14;
	localparam logic [4:0] ESC_K_EC   = 5'h08;
	localparam logic [4:0] ESC_K_EL   = 5'h15;
	localparam logic [4:0] ESC_K_CMD  = 5'h18;
	localparam logic [4:0] ESC_K_HELP = 5'h1f;

	// Configuration register indexes.
	localparam logic [1:0] CFG_ESCAPE = 2'd0;
	localparam logic [1:0] CFG_RAW    = 2'd1;
	localparam logic [1:0] CFG_CONV   = 2'd2;

	localparam logic [7:0] ESCAPE_RESET = 8'd29;

	// Pending substate between keys.
	typedef enum logic [1:0] {
		SUB_NONE = 2'd0,
		SUB_LIT  = 2'd1,
		SUB_ESC  = 2'd2
	} tle_sub_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;
		logic decode;
		logic put2;
		logic wprime;
		logic wstep;
		logic eval;
		logic load;
	} tle_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic two_puts;
		logic word_erase;
		logic fill_zero;
		logic word_done;
		logic out_free;
		logic last_item;
	} tle_sts_t;

	// Telnet command for a key in the escape substate.
	function automatic logic [7:0] esc_command(input logic [4:0] k5);
		logic [7:0] r;
		case (k5)
			ESC_K_BRK: r = TN_BRK;
			ESC_K_IP:  r = TN_IP;
			ESC_K_AO:  r = TN_AO;
			ESC_K_AYT: r = TN_AYT;
			ESC_K_EC:  r = TN_EC;
			ESC_K_EL:  r = TN_EL;
			default:   r = TN_NONE;
		endcase
		return r;
	endfunction

	// Telnet command for a key in conversational cooked mode.
	function automatic logic [7:0] conv_command(input logic [6:0] k7);
		logic [7:0] r;
		case (k7)
			{2'b00, ESC_K_BRK}: r = TN_BRK;
			{2'b00, ESC_K_IP}:  r = TN_IP;
			{2'b00, ESC_K_AO}:  r = TN_AO;
			{2'b00, ESC_K_AYT}: r = TN_AYT;
			default:            r = TN_NONE;
		endcase
		return r;
	endfunction

	// Word separators: space, tab, LF, VT, FF and CR.
	function automatic logic is_space(input logic [7:0] b);
		return (b == KEY_SP) || ((b >= KEY_TAB) && (b <= KEY_CR));
	endfunction

endpackage

// ----- hdl/tle_if.sv -----
// Keyboard byte channel.
interface tle_key_if;
	logic       valid;
	logic       ready;
	logic [7:0] key_byte;

	modport source (output valid, output key_byte, input ready);
	modport sink (input valid, input key_byte, output ready);
endinterface

// Result channel.
interface tle_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       data_valid;
	logic       last_of_run;
	logic [6:0] erased_count;
	logic       go_command_mode;
	logic       show_help;
	logic       reprint_request;
	logic       line_pending;

	modport source (output valid, output data_byte, output data_valid, output last_of_run,
		output erased_count, output go_command_mode, output show_help,
		output reprint_request, output line_pending, input ready);
	modport sink (input valid, input data_byte, input data_valid, input last_of_run,
		input erased_count, input go_command_mode, input show_help,
		input reprint_request, input line_pending, output ready);
endinterface

// Configuration write channel.
interface tle_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/tle_ctrl.sv -----
module tle_ctrl import tle_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     key_valid,
	output logic     key_ready,
	input  tle_sts_t sts,
	output tle_cmd_t cmd
);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_DECODE = 7'b0000010,
		ST_PUT2   = 7'b0000100,
		ST_WPRIME = 7'b0001000,
		ST_WSTEP  = 7'b0010000,
		ST_EVAL   = 7'b0100000,
		ST_EMIT   = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		key_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				key_ready = 1'b1;
				if (key_valid) begin
					cmd.take = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.decode = 1'b1;
				if (sts.two_puts) begin
					state_d = ST_PUT2;
				end else if (sts.word_erase) begin
					state_d = ST_WPRIME;
				end else begin
					state_d = ST_EVAL;
				end
			end
			ST_PUT2: begin
				cmd.put2 = 1'b1;
				state_d  = ST_EVAL;
			end
			ST_WPRIME: begin
				cmd.wprime = 1'b1;
				state_d    = sts.fill_zero ? ST_EVAL : ST_WSTEP;
			end
			ST_WSTEP: begin
				cmd.wstep = 1'b1;
				if (sts.word_done) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					if (sts.last_item) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- hdl/tle_datapath.sv -----
module tle_datapath import tle_pkg::*; #(
	parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     key_valid,
	input  logic     key_ready,
	input  logic [7:0] key_byte,
	tle_res_if.source result,
	tle_cfg_if.sink   cfg,
	input  tle_cmd_t cmd,
	output tle_sts_t sts
);

	localparam int AW = $clog2(LINE_DEPTH);
	localparam int CW = $clog2(LINE_DEPTH + 1);
	localparam int XW = CW + 7;

	typedef enum logic [1:0] {
		ER_NONE,
		ER_ONE,
		ER_ALL,
		ER_WORD
	} erase_t;

	typedef struct packed {
		logic [1:0] put_cnt;
		logic [7:0] p0;
		logic [7:0] p1;
		logic       cap;
		logic       rel;
		logic       go;
		logic       hp;
		logic       rp;
		erase_t     er;
		tle_sub_t   nsub;
	} dec_t;

	// Configuration registers.
	logic [7:0] esc_char_q;
	logic       raw_q;
	logic       conv_q;

	// Item state.
	logic [7:0]    key_q;
	tle_sub_t      sub_q;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] erased_q;
	logic          go_q, help_q, reprint_q;
	logic [7:0]    put1_q;
	logic          cap_q, rel_q, seen_q;
	logic [CW-1:0] n_q, idx_q;

	// Line store.
	logic [7:0]    mem [LINE_DEPTH];
	logic [7:0]    rdata_q;
	logic          wr_en, rd_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [7:0]    wr_data;

	// Output register.
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          out_dv_q, out_last_q, out_go_q, out_help_q, out_rp_q, out_pend_q;
	logic [6:0]    out_erased_q;

	dec_t          dec;
	tle_sub_t      eff_sub;
	logic [7:0]    k7b;
	logic [7:0]    esc_cmd, cnv_cmd;
	logic          fill_room;
	logic          rel_now;
	logic [XW-1:0] erased_x;

	// Configuration writes.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_char_q <= ESCAPE_RESET;
			raw_q      <= 1'b0;
			conv_q     <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_ESCAPE: esc_char_q <= cfg.data;
				CFG_RAW:    raw_q      <= cfg.data[0];
				CFG_CONV:   conv_q     <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Key decode, evaluated in the decode cycle.
	assign k7b     = {1'b0, key_q[6:0]};
	assign esc_cmd = esc_command(key_q[4:0]);
	assign cnv_cmd = conv_command(key_q[6:0]);

	always_comb begin
		eff_sub = sub_q;
		if ((sub_q == SUB_ESC) && !raw_q) begin
			eff_sub = SUB_NONE;
		end
		if ((sub_q == SUB_LIT) && raw_q) begin
			eff_sub = SUB_NONE;
		end
	end

	always_comb begin
		dec         = '0;
		dec.p0      = key_q;
		dec.er      = ER_NONE;
		dec.nsub    = SUB_NONE;
		if (eff_sub == SUB_LIT) begin
			dec.put_cnt = 2'd1;
			dec.cap     = 1'b1;
		end else if (eff_sub == SUB_ESC) begin
			dec.rel = 1'b1;
			if (key_q == esc_char_q) begin
				dec.put_cnt = 2'd1;
			end else if (esc_cmd != TN_NONE) begin
				dec.put_cnt = 2'd2;
				dec.p0      = IAC_BYTE;
				dec.p1      = esc_cmd;
			end else if (key_q[4:0] == ESC_K_CMD) begin
				dec.go = 1'b1;
			end else if (key_q[4:0] == ESC_K_HELP) begin
				dec.hp = 1'b1;
			end
		end else if (raw_q) begin
			if (key_q == esc_char_q) begin
				dec.nsub = SUB_ESC;
			end else begin
				dec.rel = 1'b1;
				if (key_q == KEY_CR) begin
					dec.put_cnt = 2'd2;
					dec.p1      = BYTE_NUL;
				end else if (key_q == IAC_BYTE) begin
					dec.put_cnt = 2'd2;
					dec.p1      = IAC_BYTE;
				end else begin
					dec.put_cnt = 2'd1;
				end
			end
		end else if (conv_q && (key_q == esc_char_q)) begin
			dec.er = ER_ALL;
			dec.go = 1'b1;
		end else if (conv_q && (k7b == KEY_CTLV)) begin
			dec.nsub = SUB_LIT;
		end else if (conv_q && (cnv_cmd != TN_NONE)) begin
			dec.put_cnt = 2'd2;
			dec.p0      = IAC_BYTE;
			dec.p1      = cnv_cmd;
			dec.rel     = 1'b1;
		end else begin
			unique case (k7b) inside
				KEY_CR, KEY_LF: begin
					dec.put_cnt = 2'd2;
					dec.p0      = KEY_CR;
					dec.p1      = KEY_LF;
					dec.rel     = 1'b1;
				end
				KEY_RUBOUT, KEY_BS: dec.er   = ER_ONE;
				KEY_CTLR:           dec.rp   = 1'b1;
				KEY_CTLU:           dec.er   = ER_ALL;
				KEY_CTLV:           dec.nsub = SUB_LIT;
				KEY_CTLW:           dec.er   = ER_WORD;
				default: begin
					dec.put_cnt = 2'd1;
					dec.cap     = 1'b1;
				end
			endcase
		end
	end

	// Status toward the controller.
	assign fill_room      = fill_q < CW'(LINE_DEPTH);
	assign sts.two_puts   = dec.put_cnt == 2'd2;
	assign sts.word_erase = dec.er == ER_WORD;
	assign sts.fill_zero  = fill_q == '0;
	assign sts.word_done  = (is_space(rdata_q) && seen_q) || (fill_q == CW'(1));
	assign sts.out_free   = !out_valid_q || result.ready;
	assign sts.last_item  = (n_q == '0) || ((idx_q + CW'(1)) == n_q);
	assign rel_now        = rel_q || (cap_q && (fill_q >= CW'(LINE_DEPTH - 1)));

	// Line store ports.
	always_comb begin
		wr_en   = 1'b0;
		wr_data = dec.p0;
		wr_addr = fill_q[AW-1:0];
		if (cmd.decode && (dec.put_cnt != 2'd0) && fill_room) begin
			wr_en = 1'b1;
		end
		if (cmd.put2 && fill_room) begin
			wr_en   = 1'b1;
			wr_data = put1_q;
		end
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		if (cmd.wprime && !sts.fill_zero) begin
			rd_en   = 1'b1;
			rd_addr = AW'(fill_q - CW'(1));
		end
		if (cmd.wstep && !sts.word_done) begin
			rd_en   = 1'b1;
			rd_addr = AW'(fill_q - CW'(2));
		end
		if (cmd.eval) begin
			rd_en = 1'b1;
		end
		if (cmd.load && !sts.last_item) begin
			rd_en   = 1'b1;
			rd_addr = AW'(idx_q + CW'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Captured key.
	always_ff @(posedge clk) begin
		if (cmd.take && key_valid && key_ready) begin
			key_q <= key_byte;
		end
	end

	// Per-key flags and deferred second byte.
	always_ff @(posedge clk) begin
		if (cmd.decode) begin
			put1_q    <= dec.p1;
			cap_q     <= dec.cap;
			rel_q     <= dec.rel;
			go_q      <= dec.go;
			help_q    <= dec.hp;
			reprint_q <= dec.rp;
		end
		if (cmd.wprime) begin
			seen_q <= 1'b0;
		end else if (cmd.wstep && !is_space(rdata_q)) begin
			seen_q <= 1'b1;
		end
	end

	// Fill count, substate, erase count and release bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			sub_q    <= SUB_NONE;
			erased_q <= '0;
			n_q      <= '0;
			idx_q    <= '0;
		end else begin
			if (cmd.decode) begin
				sub_q <= dec.nsub;
				unique case (dec.er)
					ER_ONE: begin
						if (!sts.fill_zero) begin
							fill_q   <= fill_q - CW'(1);
							erased_q <= CW'(1);
						end else begin
							erased_q <= '0;
						end
					end
					ER_ALL: begin
						fill_q   <= '0;
						erased_q <= fill_q;
					end
					default: begin
						erased_q <= '0;
						if ((dec.put_cnt != 2'd0) && fill_room) begin
							fill_q <= fill_q + CW'(1);
						end
					end
				endcase
			end
			if (cmd.put2 && fill_room) begin
				fill_q <= fill_q + CW'(1);
			end
			if (cmd.wstep) begin
				fill_q   <= fill_q - CW'(1);
				erased_q <= erased_q + CW'(1);
			end
			if (cmd.eval) begin
				idx_q <= '0;
				n_q   <= rel_now ? fill_q : '0;
				if (rel_now) begin
					fill_q <= '0;
				end
			end
			if (cmd.load) begin
				idx_q <= idx_q + CW'(1);
			end
		end
	end

	// Output register.
	assign erased_x = XW'(erased_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_byte_q   <= (n_q != '0) ? rdata_q : BYTE_NUL;
			out_dv_q     <= n_q != '0;
			out_last_q   <= sts.last_item;
			out_erased_q <= erased_x[6:0];
			out_go_q     <= go_q;
			out_help_q   <= help_q;
			out_rp_q     <= reprint_q;
			out_pend_q   <= !sts.fill_zero;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.data_byte       = out_byte_q;
	assign result.data_valid      = out_dv_q;
	assign result.last_of_run     = out_last_q;
	assign result.erased_count    = out_erased_q;
	assign result.go_command_mode = out_go_q;
	assign result.show_help       = out_help_q;
	assign result.reprint_request = out_rp_q;
	assign result.line_pending    = out_pend_q;

	// The line never holds more than the store depth.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(LINE_DEPTH))
		else $error("fill count beyond store depth");

	// A result is loaded only when the output register can take it.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!out_valid_q || result.ready))
		else $error("output register overwritten");

	// Each erase-word step removes a byte that is really held.
	a_wstep_fill: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wstep |-> (fill_q != '0))
		else $error("erase word step on empty line");

	// The second byte of a pair follows its decode cycle.
	a_put2_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.put2 |-> $past(cmd.decode))
		else $error("second byte without decode");

endmodule

// ----- hdl/tty_line_editor_telnet.sv -----
// Keyboard line discipline for a telnet-style session.
// Channels: key carries one keyboard byte per transaction; result carries the
// released bytes of that key, one transaction per byte, with last_of_run on the
// final one, or a single transaction with data_valid low when nothing is
// released. cfg writes escape_char (index 0), raw_select (1) and
// conversation_on (2); it is always ready and should be used while idle.
// Sequence: a key is taken in the idle state and decoded in the next cycle;
// a two-byte append then writes its second byte in the put2 state, and every
// key passes an evaluation state before its first result is loaded into the
// output register. Erase word walks the line store backward, one byte per
// cycle. Released bytes stream out of the single-port line store at one byte
// per cycle while the receiver is ready.
// The next key is taken as soon as the last result sits in the output
// register. When the receiver stalls, the output register holds its
// transaction and the block waits before loading the next result.
// Reset empties the line, clears any pending substate and restores the
// configuration defaults; line store contents are not cleared.
module tty_line_editor_telnet import tle_pkg::*; #(
	parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	tle_key_if.sink   key,
	tle_res_if.source result,
	tle_cfg_if.sink   cfg
);

	tle_cmd_t cmd;
	tle_sts_t sts;

	// Controller.
	tle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_valid (key.valid),
		.key_ready (key.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath with line store and output register.
	tle_datapath #(
		.LINE_DEPTH (LINE_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_valid (key.valid),
		.key_ready (key.ready),
		.key_byte  (key.key_byte),
		.result    (result),
		.cfg       (cfg),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ----- tb/sv/tb_tty_line_editor_telnet.sv -----
module tb_tty_line_editor_telnet;
	timeunit 1ns;
	timeprecision 1ps;
	import tle_pkg::*;

	localparam int LINE_DEPTH = LINE_DEPTH_DEF;
	// Covers an erase-word walk over a full line plus the decode cycles.
	localparam int SETTLE_CYCLES = LINE_DEPTH + 8;

	localparam logic [4:0] ESC_KEYS [8] = '{ESC_K_BRK, ESC_K_IP, ESC_K_AO, ESC_K_AYT,
		ESC_K_EC, ESC_K_EL, ESC_K_CMD, ESC_K_HELP};
	localparam logic [7:0] EDIT_KEYS [6] = '{KEY_BS, KEY_RUBOUT, KEY_CTLR, KEY_CTLU,
		KEY_CTLV, KEY_CTLW};
	localparam logic [7:0] SEPARATORS [4] = '{KEY_SP, KEY_TAB, 8'h0b, 8'h0c};

	typedef struct packed {
		logic [7:0] data_byte;
		logic       data_valid;
		logic       last_of_run;
		logic [6:0] erased_count;
		logic       go_command_mode;
		logic       show_help;
		logic       reprint_request;
		logic       line_pending;
	} editor_result_t;

	typedef struct {
		bit             is_cfg;
		logic [1:0]     reg_index;
		logic [7:0]     value;
		bit             typed;
		editor_result_t known;
	} script_row_t;

	typedef struct {
		logic [7:0] esc;
		bit         raw;
		bit         conv;
		bit         steady;
		int         burst;
	} phase_t;

	logic clk;
	logic arst_n;

	tle_key_if key_ch();
	tle_res_if res_ch();
	tle_cfg_if cfg_ch();

	tty_line_editor_telnet #(.LINE_DEPTH(LINE_DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.key(key_ch),
		.result(res_ch),
		.cfg(cfg_ch)
	);

	// Mirror of the editor state and its registers.
	logic [7:0] line_bytes [LINE_DEPTH];
	int         fill_level;
	tle_sub_t   held_sub;
	logic [7:0] esc_key;
	bit         raw_mode;
	bit         chat_mode;

	editor_result_t key_outputs[$];
	editor_result_t results_due[$];
	int             mismatches;
	int             sink_hold;
	bit             steady_phase;
	int             burst_left;
	bit             esc_follow;

	// Clock.
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Random pause length: mostly none, sometimes short, rarely long.
	function automatic int pause_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void store_byte(input logic [7:0] b);
		if (fill_level < LINE_DEPTH) begin
			line_bytes[fill_level] = b;
			fill_level++;
		end
	endfunction

	// Telnet command for a control key; edit commands only follow the escape byte.
	function automatic logic [7:0] telnet_cmd(input logic [4:0] k, input bit with_edit);
		case (k)
			ESC_K_BRK: return TN_BRK;
			ESC_K_IP:  return TN_IP;
			ESC_K_AO:  return TN_AO;
			ESC_K_AYT: return TN_AYT;
			ESC_K_EC:  return with_edit ? TN_EC : TN_NONE;
			ESC_K_EL:  return with_edit ? TN_EL : TN_NONE;
			default:   return TN_NONE;
		endcase
	endfunction

	function automatic bit is_separator(input logic [7:0] b);
		return (b == KEY_SP) || (b inside {[KEY_TAB:KEY_CR]});
	endfunction

	// Apply one key to the mirror and build the transactions it releases.
	function automatic void edit_key(input logic [7:0] key_in);
		logic [7:0]     c;
		logic [7:0]     esc_cmd;
		logic [7:0]     conv_cmd;
		tle_sub_t       sub;
		bit             release_line;
		bit             gocmd;
		bit             help;
		bit             reprint;
		bit             seen;
		int             erased;
		int             n;
		int             count;
		editor_result_t r;

		c = key_in;
		release_line = 1'b0;
		gocmd = 1'b0;
		help = 1'b0;
		reprint = 1'b0;
		seen = 1'b0;
		erased = 0;
		key_outputs.delete();
		esc_cmd = telnet_cmd(c[4:0], 1'b1);
		conv_cmd = (c[6:5] == 2'b00) ? telnet_cmd(c[4:0], 1'b0) : TN_NONE;

		// A pending substate only counts in the mode it was armed for.
		sub = held_sub;
		if (sub == SUB_ESC && !raw_mode) sub = SUB_NONE;
		if (sub == SUB_LIT && raw_mode) sub = SUB_NONE;
		held_sub = SUB_NONE;

		if (sub == SUB_LIT) begin
			store_byte(c);
			release_line = (fill_level >= LINE_DEPTH - 1);
		end else if (sub == SUB_ESC) begin
			if (c == esc_key) begin
				store_byte(c);
			end else if (esc_cmd != TN_NONE) begin
				store_byte(IAC_BYTE);
				store_byte(esc_cmd);
			end else if (c[4:0] == ESC_K_CMD) begin
				gocmd = 1'b1;
			end else if (c[4:0] == ESC_K_HELP) begin
				help = 1'b1;
			end
			release_line = 1'b1;
		end else if (raw_mode) begin
			if (c == esc_key) begin
				held_sub = SUB_ESC;
			end else begin
				if (c == KEY_CR) begin
					store_byte(KEY_CR);
					c = BYTE_NUL;
				end else if (c == IAC_BYTE) begin
					store_byte(IAC_BYTE);
				end
				store_byte(c);
				release_line = 1'b1;
			end
		end else if (chat_mode && c == esc_key) begin
			erased = fill_level;
			fill_level = 0;
			gocmd = 1'b1;
		end else if (chat_mode && c[6:0] == KEY_CTLV[6:0]) begin
			held_sub = SUB_LIT;
		end else if (chat_mode && conv_cmd != TN_NONE) begin
			store_byte(IAC_BYTE);
			store_byte(conv_cmd);
			release_line = 1'b1;
		end else begin
			case (c[6:0])
				KEY_CR[6:0], KEY_LF[6:0]: begin
					store_byte(KEY_CR);
					store_byte(KEY_LF);
					release_line = 1'b1;
				end
				KEY_RUBOUT[6:0], KEY_BS[6:0]: begin
					if (fill_level > 0) begin
						fill_level--;
						erased = 1;
					end
				end
				KEY_CTLR[6:0]: begin
					reprint = 1'b1;
				end
				KEY_CTLU[6:0]: begin
					erased = fill_level;
					fill_level = 0;
				end
				KEY_CTLV[6:0]: begin
					held_sub = SUB_LIT;
				end
				KEY_CTLW[6:0]: begin
					// Drop trailing separators, then the word, stopping at the separator before it.
					while (fill_level > 0) begin
						fill_level--;
						erased++;
						if (is_separator(line_bytes[fill_level])) begin
							if (seen) break;
						end else begin
							seen = 1'b1;
						end
					end
				end
				default: begin
					store_byte(c);
					release_line = (fill_level >= LINE_DEPTH - 1);
				end
			endcase
		end

		n = release_line ? fill_level : 0;
		if (release_line) fill_level = 0;
		count = (n == 0) ? 1 : n;
		for (int i = 0; i < count; i++) begin
			r.data_byte = (n != 0) ? line_bytes[i] : BYTE_NUL;
			r.data_valid = (n != 0);
			r.last_of_run = (i == count - 1);
			r.erased_count = erased[6:0];
			r.go_command_mode = gocmd;
			r.show_help = help;
			r.reprint_request = reprint;
			r.line_pending = (fill_level > 0);
			key_outputs.push_back(r);
		end
	endfunction

	// Single transaction with nothing released.
	function automatic editor_result_t quiet(input logic [6:0] erased, input bit gocmd,
		input bit help, input bit reprint, input bit pending);
		editor_result_t r;
		r.data_byte = BYTE_NUL;
		r.data_valid = 1'b0;
		r.last_of_run = 1'b1;
		r.erased_count = erased;
		r.go_command_mode = gocmd;
		r.show_help = help;
		r.reprint_request = reprint;
		r.line_pending = pending;
		return r;
	endfunction

	function automatic script_row_t key_row(input logic [7:0] b);
		script_row_t row;
		row.is_cfg = 1'b0;
		row.reg_index = CFG_ESCAPE;
		row.value = b;
		row.typed = 1'b0;
		row.known = '0;
		return row;
	endfunction

	function automatic script_row_t typed_row(input logic [7:0] b, input editor_result_t res);
		script_row_t row;
		row = key_row(b);
		row.typed = 1'b1;
		row.known = res;
		return row;
	endfunction

	function automatic script_row_t cfg_row(input logic [1:0] idx, input logic [7:0] v);
		script_row_t row;
		row = key_row(v);
		row.is_cfg = 1'b1;
		row.reg_index = idx;
		return row;
	endfunction

	// Random key shaped by the current mode: escape pairs in raw mode,
	// words, edits and line ends in cooked mode, plus some noise.
	function automatic logic [7:0] next_key();
		int         r;
		int         pick;
		logic [7:0] b;
		r = $urandom_range(0, 99);
		if (raw_mode) begin
			if (esc_follow) begin
				esc_follow = 1'b0;
				pick = $urandom_range(0, 7);
				if (r < 12) b = esc_key;
				else if (r < 85) b = {3'($urandom_range(0, 7)), ESC_KEYS[pick]};
				else b = 8'($urandom);
			end else if (r < 20) begin
				b = esc_key;
				esc_follow = 1'b1;
			end else if (r < 30) begin
				b = KEY_CR;
			end else if (r < 40) begin
				b = IAC_BYTE;
			end else begin
				b = 8'($urandom);
			end
		end else if (burst_left > 0) begin
			burst_left--;
			b = 8'($urandom_range(8'h21, 8'h7e));
		end else if (r < 45) begin
			b = 8'($urandom_range(8'h21, 8'h7e));
		end else if (r < 55) begin
			b = SEPARATORS[$urandom_range(0, 3)];
		end else if (r < 65) begin
			pick = $urandom_range(0, 5);
			b = {1'($urandom_range(0, 1)), EDIT_KEYS[pick][6:0]};
		end else if (r < 71) begin
			b = {1'($urandom_range(0, 1)), ($urandom_range(0, 1) ? KEY_CR[6:0] : KEY_LF[6:0])};
		end else if (r < 75) begin
			b = esc_key;
		end else if (r < 80) begin
			pick = $urandom_range(0, 3);
			b = {1'($urandom_range(0, 1)), 2'b00, ESC_KEYS[pick]};
		end else if (r < 82) begin
			burst_left = $urandom_range(40, 70);
			b = 8'h41;
		end else begin
			b = 8'($urandom);
		end
		return b;
	endfunction

	// Offer one key, wait for its transaction and record what it must release.
	task automatic send_key(input logic [7:0] b, input bit typed, input editor_result_t known);
		int gap;
		cfg_ch.valid <= 1'b0;
		gap = steady_phase ? 0 : pause_cycles();
		if (gap > 0) begin
			key_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		key_ch.valid <= 1'b1;
		key_ch.key_byte <= b;
		do @(posedge clk); while (!key_ch.ready);
		edit_key(b);
		if (typed) begin
			results_due.push_back(known);
		end else begin
			foreach (key_outputs[i]) results_due.push_back(key_outputs[i]);
		end
	endtask

	// Register write; valid is left high so back-to-back writes stay continuous.
	task automatic write_reg(input logic [1:0] idx, input logic [7:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			CFG_ESCAPE: esc_key = v;
			CFG_RAW:    raw_mode = v[0];
			CFG_CONV:   chat_mode = v[0];
			default:    ;
		endcase
	endtask

	// Hold off the sender until every owed transaction has come and the block is idle.
	task automatic settle();
		key_ch.valid <= 1'b0;
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
		while (results_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic flag_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_result();
		editor_result_t want;
		if (results_due.size() == 0) begin
			$error("unexpected result transaction: data_byte %0h data_valid %0b",
				res_ch.data_byte, res_ch.data_valid);
			mismatches++;
		end else begin
			want = results_due.pop_front();
			flag_field("data_byte", want.data_byte, res_ch.data_byte);
			flag_field("data_valid", 8'(want.data_valid), 8'(res_ch.data_valid));
			flag_field("last_of_run", 8'(want.last_of_run), 8'(res_ch.last_of_run));
			flag_field("erased_count", 8'(want.erased_count), 8'(res_ch.erased_count));
			flag_field("go_command_mode", 8'(want.go_command_mode), 8'(res_ch.go_command_mode));
			flag_field("show_help", 8'(want.show_help), 8'(res_ch.show_help));
			flag_field("reprint_request", 8'(want.reprint_request), 8'(res_ch.reprint_request));
			flag_field("line_pending", 8'(want.line_pending), 8'(res_ch.line_pending));
		end
	endtask

	// Result side: check each transaction and stall ready at random.
	always @(posedge clk) begin
		if (res_ch.valid && res_ch.ready) check_result();
		if (sink_hold > 0) sink_hold--;
		else if (!steady_phase && $urandom_range(0, 3) == 0) sink_hold = pause_cycles();
		res_ch.ready <= (sink_hold == 0);
	end

	// Stimulus.
	initial begin
		script_row_t script[$];
		phase_t      plan[7];

		arst_n = 1'b0;
		key_ch.valid = 1'b0;
		key_ch.key_byte = BYTE_NUL;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_ESCAPE;
		cfg_ch.data = BYTE_NUL;
		res_ch.ready = 1'b0;
		mismatches = 0;
		sink_hold = 0;
		steady_phase = 1'b0;
		burst_left = 0;
		esc_follow = 1'b0;
		fill_level = 0;
		held_sub = SUB_NONE;
		esc_key = ESCAPE_RESET;
		raw_mode = 1'b0;
		chat_mode = 1'b0;
		foreach (line_bytes[i]) line_bytes[i] = BYTE_NUL;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		script = '{
			// Cooked editing with reset settings.
			typed_row(KEY_RUBOUT, quiet(7'd0, 0, 0, 0, 0)),
			typed_row(8'h61, quiet(7'd0, 0, 0, 0, 1)),
			key_row(8'h80),
			key_row(KEY_SP),
			key_row(8'h62),
			key_row(KEY_CTLW),
			typed_row(KEY_CTLR, quiet(7'd0, 0, 0, 1, 1)),
			key_row(KEY_CTLU),
			key_row(KEY_CTLV),
			key_row(KEY_CR),
			key_row(8'h8d),
			typed_row(IAC_BYTE, quiet(7'd0, 0, 0, 0, 0)),
			// Conversational keys, escape discarding the line, literal next.
			cfg_row(CFG_CONV, 8'd1),
			key_row(8'h41),
			key_row(ESCAPE_RESET),
			key_row(8'h83),
			key_row(8'h61),
			key_row(8'h96),
			// Raw mode drops the literal and releases the held byte with its own.
			cfg_row(CFG_RAW, 8'd1),
			key_row(8'h41),
			key_row(KEY_CR),
			key_row(IAC_BYTE),
			typed_row(ESCAPE_RESET, quiet(7'd0, 0, 0, 0, 0)),
			key_row(8'h02),
			key_row(ESCAPE_RESET),
			// Leaving raw mode drops the armed escape.
			cfg_row(CFG_RAW, 8'd0),
			key_row(8'h3f),
			cfg_row(CFG_RAW, 8'd1),
			cfg_row(CFG_ESCAPE, 8'hff),
			typed_row(8'hff, quiet(7'd0, 0, 0, 0, 1)),
			key_row(8'h5f),
			cfg_row(CFG_ESCAPE, 8'h00),
			cfg_row(CFG_RAW, 8'd0),
			cfg_row(CFG_CONV, 8'd0),
			key_row(BYTE_NUL),
			key_row(KEY_LF)
		};

		foreach (script[i]) begin
			if (script[i].is_cfg) begin
				settle();
				write_reg(script[i].reg_index, script[i].value);
			end else begin
				send_key(script[i].value, script[i].typed, script[i].known);
			end
		end

		// Random phases over several register settings.
		plan = '{
			'{ESCAPE_RESET, 1'b0, 1'b0, 1'b0, 66},
			'{ESCAPE_RESET, 1'b0, 1'b1, 1'b0, 0},
			'{ESCAPE_RESET, 1'b1, 1'b0, 1'b1, 0},
			'{8'hff, 1'b1, 1'b1, 1'b0, 0},
			'{8'h00, 1'b0, 1'b1, 1'b0, 0},
			'{8'h00, 1'b1, 1'b0, 1'b0, 0},
			'{ESCAPE_RESET, 1'b0, 1'b0, 1'b1, 0}
		};
		plan[5].esc = 8'($urandom_range(0, 255));

		foreach (plan[p]) begin
			settle();
			write_reg(CFG_ESCAPE, plan[p].esc);
			write_reg(CFG_RAW, {7'd0, plan[p].raw});
			write_reg(CFG_CONV, {7'd0, plan[p].conv});
			steady_phase = plan[p].steady;
			burst_left = plan[p].burst;
			esc_follow = 1'b0;
			repeat (58) begin
				send_key(next_key(), 1'b0, '0);
				if ($urandom_range(0, 99) == 0) settle();
			end
		end

		// Drain.
		key_ch.valid <= 1'b0;
		steady_phase = 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("tty_line_editor_telnet test passed");
		end else begin
			$display("tty_line_editor_telnet test failed");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#16000000;
		$display("tty_line_editor_telnet test failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/tle_pkg.sv
hdl/tle_if.sv
hdl/tle_ctrl.sv
hdl/tle_datapath.sv
hdl/tty_line_editor_telnet.sv
tb/sv/tb_tty_line_editor_telnet.sv
